// ===== design/uas_pkg.sv =====
// Package for the UTF-8 accent stripper: transaction types, queue entry type and the transliteration table.
`timescale 1ns / 1ps
package uas_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic       two_chars;
        logic [6:0] char0;
        logic [6:0] char1;
    } t_chars;

    function automatic t_chars translit(input logic [15:0] cp);
        t_chars r;
        logic   hit;
        r   = '0;
        hit = 1'b1;
        case (cp) inside
            [16'h00E0:16'h00E5]: r.char0 = 7'h61;
            [16'h00C0:16'h00C5]: r.char0 = 7'h41;
            [16'h00E8:16'h00EB]: r.char0 = 7'h65;
            [16'h00C8:16'h00CB]: r.char0 = 7'h45;
            [16'h00EC:16'h00EF]: r.char0 = 7'h69;
            [16'h00CC:16'h00CF]: r.char0 = 7'h49;
            [16'h00F2:16'h00F6]: r.char0 = 7'h6F;
            [16'h00D2:16'h00D6]: r.char0 = 7'h4F;
            [16'h00F9:16'h00FC]: r.char0 = 7'h75;
            [16'h00D9:16'h00DC]: r.char0 = 7'h55;
            16'h00E7:            r.char0 = 7'h63;
            16'h00C7:            r.char0 = 7'h43;
            16'h00F1:            r.char0 = 7'h6E;
            16'h00D1:            r.char0 = 7'h4E;
            16'h00FD, 16'h00FF:  r.char0 = 7'h79;
            16'h00DD:            r.char0 = 7'h59;
            [16'h2010:16'h2015]: r.char0 = 7'h2D;
            16'h0153: begin
                r.char0     = 7'h6F;
                r.char1     = 7'h65;
                r.two_chars = 1'b1;
            end
            16'h0152: begin
                r.char0     = 7'h4F;
                r.char1     = 7'h45;
                r.two_chars = 1'b1;
            end
            16'h00E6: begin
                r.char0     = 7'h61;
                r.char1     = 7'h65;
                r.two_chars = 1'b1;
            end
            16'h00C6: begin
                r.char0     = 7'h41;
                r.char1     = 7'h45;
                r.two_chars = 1'b1;
            end
            [16'h0000:16'h007F]: r.char0 = cp[6:0];
            default:             hit = 1'b0;
        endcase
        translit = hit ? r : '0;
    endfunction

    function automatic logic translit_hit(input logic [15:0] cp);
        logic h;
        case (cp) inside
            [16'h00E0:16'h00E6], [16'h00C0:16'h00C7], [16'h00E7:16'h00EF],
            [16'h00C8:16'h00CF], [16'h00F1:16'h00F6], [16'h00D1:16'h00D6],
            [16'h00F9:16'h00FD], [16'h00D9:16'h00DD], 16'h00FF,
            [16'h2010:16'h2015], 16'h0152, 16'h0153,
            [16'h0000:16'h007F]: h = 1'b1;
            default:             h = 1'b0;
        endcase
        translit_hit = h;
    endfunction

endpackage

// ===== design/uas_front.sv =====
// Front part: accepts bytes, holds pending sequence bytes, decodes and transliterates code points.
`timescale 1ns / 1ps
module uas_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  uas_pkg::t_in_item i_in_data,
    input  logic              i_queue_full,
    output logic              o_push,
    output uas_pkg::t_chars   o_push_data
);

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_LEAD = 2'd1;
    localparam logic [1:0] CNT_BOTH = 2'd2;

    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [1:0]  r_cnt, n_cnt;
    logic        accept;
    logic        cp_vld;
    logic [15:0] cp;
    logic [7:0]  b;
    logic        last;
    logic        b_cont;
    logic        b_lead;

    assign accept = i_in_valid && !i_queue_full;
    assign b      = i_in_data.in_byte;
    assign last   = i_in_data.string_end;
    assign b_cont = (b[7:6] == 2'b10);
    assign b_lead = (b[7:5] == 3'b110) || (b[7:4] == 4'b1110);

    always_comb begin
        cp_vld   = 1'b0;
        cp       = '0;
        n_cnt    = CNT_NONE;
        n_lead   = '0;
        n_second = '0;
        if ((r_cnt == CNT_LEAD) && b_cont) begin
            if (r_lead[7:5] == 3'b110) begin
                cp_vld = 1'b1;
                cp     = {5'd0, r_lead[4:0], b[5:0]};
            end else if (!last) begin
                n_cnt    = CNT_BOTH;
                n_lead   = r_lead;
                n_second = b;
            end
        end else if ((r_cnt != CNT_NONE) && (r_cnt != CNT_LEAD) && b_cont) begin
            cp_vld = 1'b1;
            cp     = {r_lead[3:0], r_second[5:0], b[5:0]};
        end else begin
            if (!b[7]) begin
                cp_vld = 1'b1;
                cp     = {8'd0, b};
            end else if (b_lead && !last) begin
                n_cnt  = CNT_LEAD;
                n_lead = b;
            end
        end
    end

    assign o_push      = accept && cp_vld && uas_pkg::translit_hit(cp);
    assign o_push_data = uas_pkg::translit(cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CNT_NONE;
            r_lead   <= '0;
            r_second <= '0;
        end else if (accept) begin
            r_cnt    <= n_cnt;
            r_lead   <= n_lead;
            r_second <= n_second;
        end
    end

endmodule

// ===== design/uas_queue.sv =====
// Short queue of transliterated entries between the front and back parts.
`timescale 1ns / 1ps
module uas_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uas_pkg::t_chars i_push_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output uas_pkg::t_chars o_head
);

    uas_pkg::t_chars r_mem [uas_pkg::QUEUE_DEPTH];
    logic [uas_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [uas_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [uas_pkg::QUEUE_AW:0]   r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (uas_pkg::QUEUE_AW+1)'(uas_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/uas_back.sv =====
// Back part: emits the one or two characters of each queued entry through an output register.
`timescale 1ns / 1ps
module uas_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_queue_empty,
    input  uas_pkg::t_chars    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output uas_pkg::t_out_item o_out_data
);

    logic               r_out_valid;
    uas_pkg::t_out_item r_out_data;
    logic               r_second_pend;
    logic [6:0]         r_second_char;
    logic               load;

    assign load        = !r_out_valid || !i_out_stall;
    assign o_pop       = load && !r_second_pend && !i_queue_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_second_pend <= 1'b0;
        end else if (load) begin
            if (r_second_pend) begin
                r_out_valid   <= 1'b1;
                r_second_pend <= 1'b0;
            end else begin
                r_out_valid   <= !i_queue_empty;
                r_second_pend <= !i_queue_empty && i_head.two_chars;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second_pend) begin
                r_out_data.ascii_char <= r_second_char;
                r_out_data.run_last   <= 1'b1;
            end else begin
                r_out_data.ascii_char <= i_head.char0;
                r_out_data.run_last   <= !i_head.two_chars;
                r_second_char         <= i_head.char1;
            end
        end
    end

endmodule

// ===== design/utf8_accent_stripper.sv =====
// Top level of the UTF-8 accent stripper.
// One byte transaction is taken per cycle while the four-entry queue between the decoding front
// and the emitting back has room; a character passes through the queue and the output register
// after its last byte is taken. Each output cycle delivers one character, so a ligature leaves as
// two characters in turn, and the queue depth sets how long input keeps flowing while the output side stalls.
`timescale 1ns / 1ps
module utf8_accent_stripper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  uas_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output uas_pkg::t_out_item o_out_data
);

    logic            push;
    uas_pkg::t_chars push_data;
    logic            pop;
    logic            full;
    logic            empty;
    uas_pkg::t_chars head;

    assign o_in_stall = full;

    uas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    uas_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_head      (head)
    );

    uas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

// ===== design/uas_checker.sv =====
// Port-level checker for the UTF-8 accent stripper and its bind statement.
`timescale 1ns / 1ps
module uas_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input uas_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input uas_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output transaction changed or vanished.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Block not quiet after reset.");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && o_out_valid && i_out_stall |=> o_in_stall)
        else $error("Input stall released while the output was stalled.");

    a_ligature_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.run_last |=> o_out_valid)
        else $error("Second character of a ligature was not ready.");

endmodule

bind utf8_accent_stripper uas_checker u_uas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/utf8_accent_stripper_tb.sv =====
// Self-checking testbench for the UTF-8 accent stripper, with its own transliteration predictor.
`timescale 1ns / 1ps
module utf8_accent_stripper_tb;

    localparam int N_RANDOM = 255;
    localparam int N_DIRECTED = 25;

    typedef struct {
        uas_pkg::t_in_item item;
        bit                known;
        int                n;
        logic [6:0]        c0;
        logic [6:0]        c1;
    } t_stim;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    uas_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    uas_pkg::t_out_item o_out_data;

    // Rows marked known carry their expected characters; the others use the predictor.
    t_stim directed_rows [0:N_DIRECTED-1] = '{
        '{'{8'h00, 1'b0}, 1'b1, 1, 7'h00, 7'h00},
        '{'{8'h7F, 1'b0}, 1'b1, 1, 7'h7F, 7'h00},
        '{'{8'h41, 1'b1}, 1'b1, 1, 7'h41, 7'h00},
        '{'{8'h80, 1'b0}, 1'b1, 0, 7'h00, 7'h00},
        '{'{8'hFF, 1'b0}, 1'b1, 0, 7'h00, 7'h00},
        '{'{8'hF0, 1'b0}, 1'b1, 0, 7'h00, 7'h00},
        '{'{8'hC3, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hA9, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hC5, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h93, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hE2, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h80, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h94, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hC0, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h80, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hE0, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h80, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h80, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hC3, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h41, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hE2, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h80, 1'b1}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hC3, 1'b0}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'h86, 1'b1}, 1'b0, 0, 7'h00, 7'h00},
        '{'{8'hC3, 1'b1}, 1'b0, 0, 7'h00, 7'h00}
    };

    t_stim              stim_rows [$];
    uas_pkg::t_out_item char_fifo [$];
    logic [7:0] held_lead;
    logic [7:0] held_second;
    logic [1:0] held_cnt;
    int        n_taken;
    int        n_bad;
    int        in_calm;
    int        out_calm;

    utf8_accent_stripper u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    function automatic int map_code(input logic [15:0] cp, output logic [6:0] c0,
                                    output logic [6:0] c1);
        c0 = 7'h00;
        c1 = 7'h00;
        if (cp >= 16'h00E0 && cp <= 16'h00E5) c0 = 7'h61;
        else if (cp >= 16'h00C0 && cp <= 16'h00C5) c0 = 7'h41;
        else if (cp >= 16'h00E8 && cp <= 16'h00EB) c0 = 7'h65;
        else if (cp >= 16'h00C8 && cp <= 16'h00CB) c0 = 7'h45;
        else if (cp >= 16'h00EC && cp <= 16'h00EF) c0 = 7'h69;
        else if (cp >= 16'h00CC && cp <= 16'h00CF) c0 = 7'h49;
        else if (cp >= 16'h00F2 && cp <= 16'h00F6) c0 = 7'h6F;
        else if (cp >= 16'h00D2 && cp <= 16'h00D6) c0 = 7'h4F;
        else if (cp >= 16'h00F9 && cp <= 16'h00FC) c0 = 7'h75;
        else if (cp >= 16'h00D9 && cp <= 16'h00DC) c0 = 7'h55;
        else if (cp == 16'h00E7) c0 = 7'h63;
        else if (cp == 16'h00C7) c0 = 7'h43;
        else if (cp == 16'h00F1) c0 = 7'h6E;
        else if (cp == 16'h00D1) c0 = 7'h4E;
        else if (cp == 16'h00FD || cp == 16'h00FF) c0 = 7'h79;
        else if (cp == 16'h00DD) c0 = 7'h59;
        else if (cp >= 16'h2010 && cp <= 16'h2015) c0 = 7'h2D;
        else if (cp == 16'h0153) begin
            c0 = 7'h6F;
            c1 = 7'h65;
            return 2;
        end else if (cp == 16'h0152) begin
            c0 = 7'h4F;
            c1 = 7'h45;
            return 2;
        end else if (cp == 16'h00E6) begin
            c0 = 7'h61;
            c1 = 7'h65;
            return 2;
        end else if (cp == 16'h00C6) begin
            c0 = 7'h41;
            c1 = 7'h45;
            return 2;
        end else if (cp < 16'h0080) c0 = cp[6:0];
        else return 0;
        return 1;
    endfunction

    function automatic bit is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic void strip_byte(input logic [7:0] b, input logic fin,
                                       output uas_pkg::t_out_item res [$]);
        logic [7:0]  seq [3];
        logic [7:0]  c;
        logic [15:0] cp;
        logic [6:0]  c0;
        logic [6:0]  c1;
        int          n;
        int          p;
        int          k;
        bit          hold;
        res = {};
        n = 0;
        p = 0;
        hold = 1'b0;
        if (held_cnt >= 1) begin
            seq[n] = held_lead;
            n++;
        end
        if (held_cnt >= 2) begin
            seq[n] = held_second;
            n++;
        end
        seq[n] = b;
        n++;
        while (p < n && !hold) begin
            c = seq[p];
            k = -1;
            if (c < 8'h80) begin
                k = map_code({8'h00, c}, c0, c1);
                p++;
            end else if (c[7:5] == 3'b110) begin
                if (p + 1 < n) begin
                    if (!is_cont(seq[p+1])) begin
                        p++;
                    end else begin
                        k = map_code({5'b0, c[4:0], seq[p+1][5:0]}, c0, c1);
                        p += 2;
                    end
                end else if (fin) begin
                    p++;
                end else begin
                    hold = 1'b1;
                end
            end else if (c[7:4] == 4'b1110) begin
                if (p + 1 < n && !is_cont(seq[p+1])) begin
                    p++;
                end else if (p + 2 < n) begin
                    if (!is_cont(seq[p+2])) begin
                        p++;
                    end else begin
                        cp = {c[3:0], seq[p+1][5:0], seq[p+2][5:0]};
                        k = map_code(cp, c0, c1);
                        p += 3;
                    end
                end else if (fin) begin
                    p++;
                end else begin
                    hold = 1'b1;
                end
            end else begin
                p++;
            end
            if (k >= 1) res.push_back('{ascii_char: c0, run_last: 1'b0});
            if (k == 2) res.push_back('{ascii_char: c1, run_last: 1'b0});
        end
        if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
        held_cnt = 2'(n - p);
        held_lead = (n - p >= 1) ? seq[p] : 8'h00;
        held_second = (n - p >= 2) ? seq[p+1] : 8'h00;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic fin);
        t_stim r;
        r = '{item: '{in_byte: b, string_end: fin}, known: 1'b0, n: 0, c0: 7'h00, c1: 7'h00};
        stim_rows.push_back(r);
    endtask

    task automatic add_code(input logic [15:0] cp, input int len);
        if (len == 1) begin
            add_byte({1'b0, cp[6:0]}, 1'b0);
        end else if (len == 2) begin
            add_byte({3'b110, cp[10:6]}, 1'b0);
            add_byte({2'b10, cp[5:0]}, 1'b0);
        end else begin
            add_byte({4'b1110, cp[15:12]}, 1'b0);
            add_byte({2'b10, cp[11:6]}, 1'b0);
            add_byte({2'b10, cp[5:0]}, 1'b0);
        end
    endtask

    // Mostly well-formed strings with random content, mixed with overlong sequences, stray and truncated bytes.
    task automatic build_random_strings();
        int n_chars;
        int kind;
        while (stim_rows.size() < N_DIRECTED + N_RANDOM) begin
            n_chars = $urandom_range(1, 8);
            repeat (n_chars) begin
                kind = $urandom_range(0, 11);
                case (kind)
                    0, 1, 2: add_code(16'($urandom_range(0, 127)), 1);
                    3, 4, 5, 6: begin
                        case ($urandom_range(0, 3))
                            0, 1: add_code(16'($urandom_range(16'h00C0, 16'h00FF)), 2);
                            2: begin
                                case ($urandom_range(0, 3))
                                    0: add_code(16'h0152, 2);
                                    1: add_code(16'h0153, 2);
                                    2: add_code(16'h00E6, 2);
                                    default: add_code(16'h00C6, 2);
                                endcase
                            end
                            default: add_code(16'($urandom_range(16'h0080, 16'h07FF)), 2);
                        endcase
                    end
                    7, 8: begin
                        if ($urandom_range(0, 1) == 0)
                            add_code(16'($urandom_range(16'h2010, 16'h2015)), 3);
                        else
                            add_code(16'($urandom_range(16'h0800, 16'hFFFF)), 3);
                    end
                    9: begin
                        if ($urandom_range(0, 1) == 0)
                            add_code(16'($urandom_range(0, 127)), 2);
                        else
                            add_code(16'($urandom_range(0, 16'h07FF)), 3);
                    end
                    10: add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            add_byte(8'($urandom_range(8'hC0, 8'hEF)), 1'b0);
                        end else begin
                            add_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
                            add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
                        end
                    end
                endcase
            end
            stim_rows[stim_rows.size()-1].item.string_end = 1'b1;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (char_fifo.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[utf8_accent_stripper] ERROR");
        $finish;
    end

    initial begin
        int gap;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        in_calm = 0;
        for (int i = 0; i < N_DIRECTED; i++) stim_rows.push_back(directed_rows[i]);
        build_random_strings();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < stim_rows.size(); i++) begin
            if (i == N_DIRECTED || i == N_DIRECTED + N_RANDOM / 2) wait_drained();
            gap = draw_wait(in_calm);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data <= stim_rows[i].item;
            do @(posedge i_clk); while (o_in_stall);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("[utf8_accent_stripper] OK");
        end else begin
            $display("[utf8_accent_stripper] ERROR");
        end
        $finish;
    end

    initial begin
        int gap;
        i_out_stall = 1'b0;
        out_calm = 0;
        forever begin
            gap = draw_wait(out_calm);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        uas_pkg::t_out_item got [$];
        uas_pkg::t_out_item want;
        t_stim              row;
        if (!i_rst_n) begin
            held_lead <= 8'h00;
            held_second <= 8'h00;
            held_cnt <= 2'd0;
            n_taken <= 0;
            n_bad <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                row = stim_rows[n_taken];
                n_taken++;
                strip_byte(i_in_data.in_byte, i_in_data.string_end, got);
                if (row.known) begin
                    if (row.n >= 1)
                        char_fifo.push_back('{ascii_char: row.c0, run_last: row.n == 1});
                    if (row.n == 2)
                        char_fifo.push_back('{ascii_char: row.c1, run_last: 1'b1});
                end else begin
                    foreach (got[k]) char_fifo.push_back(got[k]);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (char_fifo.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected character %h run_last %b",
                                 o_out_data.ascii_char, o_out_data.run_last);
                end else begin
                    want = char_fifo.pop_front();
                    if (o_out_data.ascii_char !== want.ascii_char ||
                        o_out_data.run_last !== want.run_last) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: char %h/%h run_last %b/%b (expected/actual)",
                                     want.ascii_char, o_out_data.ascii_char,
                                     want.run_last, o_out_data.run_last);
                    end
                end
            end
        end
    end

endmodule
